// ----- hdl/vel_pkg.sv -----
`timescale 1ns / 1ps

package vel_pkg;

	localparam int MAX_LENGTH     = 65536;
	localparam int MAX_COMPONENTS = 15;

	localparam int POS_CAP  = ((MAX_LENGTH - 1) > 65535) ? 65535 : (MAX_LENGTH - 1);
	localparam int COMP_LIM = (MAX_COMPONENTS > 15) ? 15 : MAX_COMPONENTS;
	localparam int COMP_CAP = (COMP_LIM < 4) ? 4 : COMP_LIM;

	localparam logic [15:0] POS_LIMIT   = 16'(POS_CAP);
	localparam logic [3:0]  PARTS_LIMIT = 4'(COMP_CAP);
	localparam logic [15:0] LINE_LIMIT  = 16'hFFFF;
	localparam logic [3:0]  VER_PARTS   = 4'd3;

	localparam logic [2:0] KIND_VAR   = 3'd0;
	localparam logic [2:0] KIND_VER   = 3'd1;
	localparam logic [2:0] KIND_OP    = 3'd2;
	localparam logic [2:0] KIND_GROUP = 3'd3;
	localparam logic [2:0] KIND_ERR   = 3'd4;
	localparam logic [2:0] KIND_END   = 3'd5;

	localparam logic [2:0] OP_GE    = 3'd0;
	localparam logic [2:0] OP_LE    = 3'd1;
	localparam logic [2:0] OP_GT    = 3'd2;
	localparam logic [2:0] OP_LT    = 3'd3;
	localparam logic [2:0] OP_NE    = 3'd4;
	localparam logic [2:0] OP_EQ    = 3'd5;
	localparam logic [2:0] OP_AND   = 3'd6;
	localparam logic [2:0] OP_OR    = 3'd7;
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] GRP_OPEN  = 3'd0;
	localparam logic [2:0] GRP_CLOSE = 3'd1;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_INVALID   = 2'd0;
	localparam logic [1:0] ERR_PARTS     = 2'd1;
	localparam logic [1:0] ERR_TRUNCATED = 2'd2;

	typedef enum logic [2:0] {
		ST_START     = 3'd0,
		ST_VARIABLE  = 3'd1,
		ST_DIGIT     = 3'd2,
		ST_STOP      = 3'd3,
		ST_SEPARATOR = 3'd4,
		ST_COMPARE   = 3'd5,
		ST_LOGICAL   = 3'd6,
		ST_EQUALITY  = 3'd7
	} lex_state_t;

	typedef struct packed {
		lex_state_t  st;
		logic [15:0] tok_begin;
		logic [3:0]  parts;
		logic [7:0]  pend;
		logic [15:0] pos;
		logic [15:0] line;
		logic [15:0] col;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{
		st:        ST_START,
		tok_begin: 16'd0,
		parts:     4'd0,
		pend:      8'd0,
		pos:       16'd0,
		line:      16'd1,
		col:       16'd1
	};

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  op;
		logic [15:0] start_offset;
		logic [15:0] end_offset;
		logic [1:0]  err_code;
		logic [3:0]  comp;
		logic [15:0] line;
		logic [15:0] col;
		logic        last;
	} res_t;

endpackage

// ----- hdl/vel_step.sv -----
`timescale 1ns / 1ps

module vel_step (
	input  vel_pkg::ctx_t cur,
	input  logic [7:0]    ch,
	output vel_pkg::ctx_t nxt,
	output vel_pkg::res_t res0,
	output vel_pkg::res_t res1,
	output logic [1:0]    res_cnt
);
	import vel_pkg::*;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_US     = 8'h5F;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_BAR    = 8'h7C;

	logic        c_zero, is_sp, is_al, is_dg, is_us, is_dot, is_eq, is_paren, is_opch;
	logic        ident, sep_ok, start_fail;
	logic        in_start, in_var, in_digit, in_stop, in_cmp, in_log, in_equ;
	logic        var_close, ver_close, num_end, log_match, rescan;
	logic        pre_v, grp_v, err_v, end_v;
	logic [1:0]  err_code;
	logic [15:0] prev;
	res_t        pre, grp, err, fin;

	assign c_zero   = (ch == CH_NUL);
	assign is_sp    = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
	assign is_al    = (ch >= CH_LO_A && ch <= CH_LO_Z) || (ch >= CH_UP_A && ch <= CH_UP_Z);
	assign is_dg    = (ch >= CH_ZERO && ch <= CH_NINE);
	assign is_us    = (ch == CH_US);
	assign is_dot   = (ch == CH_DOT);
	assign is_eq    = (ch == CH_EQ);
	assign is_paren = (ch == CH_LPAREN) || (ch == CH_RPAREN);
	assign is_opch  = is_paren || is_eq || (ch == CH_GT) || (ch == CH_LT) ||
			(ch == CH_AMP) || (ch == CH_BAR) || (ch == CH_BANG);
	assign ident      = is_al || is_dg || is_us;
	assign sep_ok     = c_zero || is_sp || is_opch;
	assign start_fail = !(sep_ok || is_al || is_us || is_dg);

	assign in_start = (cur.st == ST_START) || (cur.st == ST_SEPARATOR);
	assign in_var   = (cur.st == ST_VARIABLE);
	assign in_digit = (cur.st == ST_DIGIT);
	assign in_stop  = (cur.st == ST_STOP);
	assign in_cmp   = (cur.st == ST_COMPARE);
	assign in_log   = (cur.st == ST_LOGICAL);
	assign in_equ   = (cur.st == ST_EQUALITY);

	assign prev      = (cur.pos != 16'd0) ? cur.pos - 16'd1 : 16'd0;
	assign num_end   = in_digit && !is_dg && !is_dot;
	assign var_close = in_var && !ident;
	assign ver_close = num_end && (cur.parts == VER_PARTS);
	assign log_match = (ch == cur.pend) && ((ch == CH_AMP) || (ch == CH_BAR));
	assign rescan    = in_start || ((var_close || ver_close) && sep_ok) ||
			(in_cmp && !is_eq);

	assign pre_v = var_close || ver_close || in_cmp || (in_log && log_match) ||
			(in_equ && is_eq);
	assign grp_v = rescan && is_paren;
	assign err_v = (rescan && start_fail) || (var_close && !sep_ok) ||
			(num_end && ((cur.parts != VER_PARTS) || !sep_ok)) ||
			(in_stop && !is_dg) || (in_log && !log_match) || (in_equ && !is_eq);
	assign end_v = c_zero && !err_v;

	always_comb begin
		if (num_end && (cur.parts != VER_PARTS)) begin
			err_code = ERR_PARTS;
		end else if ((in_log || in_equ) && c_zero) begin
			err_code = ERR_TRUNCATED;
		end else begin
			err_code = ERR_INVALID;
		end
	end

	always_comb begin
		pre = '0;
		pre.start_offset = cur.tok_begin;
		pre.end_offset   = cur.pos;
		case (cur.st)
			ST_VARIABLE: begin
				pre.kind       = KIND_VAR;
				pre.end_offset = prev;
			end
			ST_DIGIT: begin
				pre.kind       = KIND_VER;
				pre.end_offset = prev;
			end
			ST_COMPARE: begin
				pre.kind = KIND_OP;
				if (is_eq) begin
					pre.op = (cur.pend == CH_GT) ? OP_GE : OP_LE;
				end else begin
					pre.op         = (cur.pend == CH_GT) ? OP_GT : OP_LT;
					pre.end_offset = cur.tok_begin;
				end
			end
			ST_LOGICAL: begin
				pre.kind = KIND_OP;
				pre.op   = (ch == CH_AMP) ? OP_AND : OP_OR;
			end
			ST_EQUALITY: begin
				pre.kind = KIND_OP;
				pre.op   = (cur.pend == CH_BANG) ? OP_NE : OP_EQ;
			end
			default: begin
				pre.kind = KIND_VAR;
			end
		endcase

		grp = '0;
		grp.kind         = KIND_GROUP;
		grp.op           = (ch == CH_RPAREN) ? GRP_CLOSE : GRP_OPEN;
		grp.start_offset = cur.pos;
		grp.end_offset   = cur.pos;

		err = '0;
		err.kind         = KIND_ERR;
		err.op           = OP_NONE;
		err.start_offset = cur.pos;
		err.end_offset   = cur.pos;
		err.err_code     = err_code;
		err.comp         = (err_code == ERR_PARTS) ? cur.parts : 4'd0;
		err.line         = cur.line;
		err.col          = cur.col;

		fin = '0;
		fin.kind         = KIND_END;
		fin.err_code     = ERR_NONE;
		fin.start_offset = cur.pos;
		fin.end_offset   = cur.pos;

		res0 = pre_v ? pre : grp_v ? grp : err_v ? err : fin;
		res1 = grp_v ? grp : err_v ? err : fin;
		res_cnt = 2'(pre_v) + 2'(grp_v) + 2'(err_v) + 2'(end_v);
		res0.last = (res_cnt == 2'd1);
		res1.last = 1'b1;
	end

	always_comb begin
		nxt = cur;
		if (err_v || end_v) begin
			nxt = CTX_RESET;
		end else begin
			case (cur.st)
				ST_DIGIT: begin
					if (is_dot) begin
						nxt.st = ST_STOP;
						if (cur.parts < PARTS_LIMIT) begin
							nxt.parts = cur.parts + 4'd1;
						end
					end else if (!is_dg) begin
						nxt.parts = 4'd0;
					end
				end
				ST_STOP: begin
					nxt.st = ST_DIGIT;
				end
				ST_COMPARE, ST_LOGICAL, ST_EQUALITY: begin
					nxt.st = ST_START;
				end
				default: begin
					nxt.st = cur.st;
				end
			endcase
			if (rescan) begin
				nxt.st = ST_START;
				if (is_al || is_us) begin
					nxt.st        = ST_VARIABLE;
					nxt.tok_begin = cur.pos;
				end else if (is_dg) begin
					nxt.st        = ST_DIGIT;
					nxt.tok_begin = cur.pos;
					nxt.parts     = 4'd1;
				end else if (is_opch && !is_paren) begin
					nxt.tok_begin = cur.pos;
					nxt.pend      = ch;
					if ((ch == CH_GT) || (ch == CH_LT)) begin
						nxt.st = ST_COMPARE;
					end else if ((ch == CH_AMP) || (ch == CH_BAR)) begin
						nxt.st = ST_LOGICAL;
					end else begin
						nxt.st = ST_EQUALITY;
					end
				end
			end
			if (ch == CH_LF) begin
				if (cur.line < LINE_LIMIT) begin
					nxt.line = cur.line + 16'd1;
				end
				nxt.col = 16'd1;
			end else if (cur.col < LINE_LIMIT) begin
				nxt.col = cur.col + 16'd1;
			end
			if (cur.pos < POS_LIMIT) begin
				nxt.pos = cur.pos + 16'd1;
			end
		end
	end

endmodule

// ----- hdl/vel_out_buf.sv -----
`timescale 1ns / 1ps

module vel_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic [1:0]    cnt_in,
	input  vel_pkg::res_t r0,
	input  vel_pkg::res_t r1,
	input  logic          stall,
	output logic          valid,
	output logic          free,
	output vel_pkg::res_t head
);
	import vel_pkg::*;

	res_t       slot0_q, slot1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign valid = (cnt_q != 2'd0);
	assign pop   = valid && !stall;
	assign free  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
	assign head  = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= cnt_in;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

// ----- hdl/version_expression_lexer.sv -----
`timescale 1ns / 1ps
// Version expression lexer.
// Input channel: char_valid / char_stall carry one ASCII byte per word on
// char_code; a zero byte ends the expression. Output channel: result_valid /
// result_stall carry one token, error or end-of-input word per cycle on the
// result_* and related ports; last_of_run marks the final word of a byte.
// A byte is registered in the input register, then lexed combinationally
// and loaded into a two-entry output buffer once the buffer is free.
// Throughput is one byte per cycle while each byte gives at most one word
// and the receiver does not stall; a byte that gives two words holds the
// input while the buffer drains its second entry.
// An error or end of input emits a final word and returns the lexer to its
// start position (offset 0, line 1, column 1) for the next expression.
// When the receiver stalls, the output word holds and the input register
// stalls the sender unless the buffer is empty or popping its last word.
// Reset empties both registers and returns the lexer to its start position.

module version_expression_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  result_kind,
	output logic [2:0]  op_code,
	output logic [15:0] start_offset,
	output logic [15:0] end_offset,
	output logic [1:0]  error_code,
	output logic [3:0]  component_count,
	output logic [15:0] error_line,
	output logic [15:0] error_column,
	output logic        last_of_run
);
	import vel_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	ctx_t       ctx_q, ctx_nxt;
	res_t       res0, res1, head;
	logic [1:0] res_cnt;
	logic       free, advance;

	assign advance    = valid_s1 && free;
	assign char_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= CTX_RESET;
		end else if (advance) begin
			ctx_q <= ctx_nxt;
		end
	end

	vel_step u_step (
		.cur     (ctx_q),
		.ch      (char_s1),
		.nxt     (ctx_nxt),
		.res0    (res0),
		.res1    (res1),
		.res_cnt (res_cnt)
	);

	vel_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.cnt_in (res_cnt),
		.r0     (res0),
		.r1     (res1),
		.stall  (result_stall),
		.valid  (result_valid),
		.free   (free),
		.head   (head)
	);

	assign result_kind     = head.kind;
	assign op_code         = head.op;
	assign start_offset    = head.start_offset;
	assign end_offset      = head.end_offset;
	assign error_code      = head.err_code;
	assign component_count = head.comp;
	assign error_line      = head.line;
	assign error_column    = head.col;
	assign last_of_run     = head.last;

endmodule

// ----- tb/sv/lexer_token_checker.sv -----
`timescale 1ns / 1ps

module lexer_token_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	input  logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [2:0]  result_kind,
	input  logic [2:0]  op_code,
	input  logic [15:0] start_offset,
	input  logic [15:0] end_offset,
	input  logic [1:0]  error_code,
	input  logic [3:0]  component_count,
	input  logic [15:0] error_line,
	input  logic [15:0] error_column,
	input  logic        last_of_run,
	output int          mismatch_count,
	output int          tokens_owed
);

	import vel_pkg::*;

	lex_state_t  lx_state;
	logic [15:0] lx_begin;
	logic [3:0]  lx_parts;
	logic [7:0]  lx_pend;
	logic [15:0] lx_offset;
	logic [15:0] lx_line;
	logic [15:0] lx_col;

	res_t step_words[2];
	int   step_count;
	res_t expected_tokens[$];
	int   faults;

	function automatic bit is_blank(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_op_char(input logic [7:0] c);
		return c == "(" || c == ")" || c == ">" || c == "<" ||
			c == "&" || c == "|" || c == "!" || c == "=";
	endfunction

	function void restart_lexer();
		lx_state  = ST_START;
		lx_begin  = 16'd0;
		lx_parts  = 4'd0;
		lx_pend   = 8'd0;
		lx_offset = 16'd0;
		lx_line   = 16'd1;
		lx_col    = 16'd1;
	endfunction

	function void put_word(input logic [2:0] kind, input logic [2:0] op,
		input logic [15:0] first, input logic [15:0] last_pos,
		input logic [1:0] code, input logic [3:0] parts,
		input logic [15:0] line, input logic [15:0] col);
		if (step_count < 2) begin
			step_words[step_count] = '{kind: kind, op: op, start_offset: first,
				end_offset: last_pos, err_code: code, comp: parts, line: line,
				col: col, last: 1'b0};
			step_count++;
		end
	endfunction

	function void raise_error(input logic [1:0] code, input logic [3:0] parts);
		put_word(KIND_ERR, OP_NONE, lx_offset, lx_offset, code, parts, lx_line, lx_col);
		restart_lexer();
	endfunction

	function void lex_byte(input logic [7:0] c);
		logic [15:0] here;
		logic [15:0] prior;
		bit again;
		bit failed;
		here = lx_offset;
		prior = (here != 16'd0) ? here - 16'd1 : 16'd0;
		step_count = 0;
		again = 1'b1;
		failed = 1'b0;
		for (int i = 0; i < 4 && again && !failed; i++) begin
			again = 1'b0;
			case (lx_state)
			ST_START: if (c != 8'd0 && !is_blank(c)) begin
				if (is_letter(c) || c == "_") begin
					lx_state = ST_VARIABLE;
					lx_begin = here;
				end else if (is_digit(c)) begin
					lx_state = ST_DIGIT;
					lx_begin = here;
					lx_parts = 4'd1;
				end else if (c == "(" || c == ")") begin
					put_word(KIND_GROUP, (c == ")") ? GRP_CLOSE : GRP_OPEN, here, here,
						ERR_NONE, 4'd0, 16'd0, 16'd0);
				end else if (is_op_char(c)) begin
					lx_state = (c == ">" || c == "<") ? ST_COMPARE :
						(c == "&" || c == "|") ? ST_LOGICAL : ST_EQUALITY;
					lx_pend = c;
					lx_begin = here;
				end else begin
					raise_error(ERR_INVALID, 4'd0);
					failed = 1'b1;
				end
			end
			ST_VARIABLE: if (!(is_letter(c) || is_digit(c) || c == "_")) begin
				put_word(KIND_VAR, OP_NONE, lx_begin, prior, ERR_NONE, 4'd0, 16'd0, 16'd0);
				lx_state = ST_SEPARATOR;
				again = 1'b1;
			end
			ST_DIGIT: if (c == ".") begin
				if (lx_parts < PARTS_LIMIT)
					lx_parts++;
				lx_state = ST_STOP;
			end else if (!is_digit(c)) begin
				if (lx_parts != VER_PARTS) begin
					raise_error(ERR_PARTS, lx_parts);
					failed = 1'b1;
				end else begin
					put_word(KIND_VER, OP_NONE, lx_begin, prior, ERR_NONE, 4'd0,
						16'd0, 16'd0);
					lx_parts = 4'd0;
					lx_state = ST_SEPARATOR;
					again = 1'b1;
				end
			end
			ST_STOP: if (is_digit(c)) begin
				lx_state = ST_DIGIT;
			end else begin
				raise_error(ERR_INVALID, 4'd0);
				failed = 1'b1;
			end
			ST_SEPARATOR: if (c == 8'd0 || is_blank(c) || is_op_char(c)) begin
				lx_state = ST_START;
				again = 1'b1;
			end else begin
				raise_error(ERR_INVALID, 4'd0);
				failed = 1'b1;
			end
			ST_COMPARE: begin
				if (c == "=") begin
					put_word(KIND_OP, (lx_pend == ">") ? OP_GE : OP_LE, lx_begin, here,
						ERR_NONE, 4'd0, 16'd0, 16'd0);
				end else begin
					put_word(KIND_OP, (lx_pend == ">") ? OP_GT : OP_LT, lx_begin, lx_begin,
						ERR_NONE, 4'd0, 16'd0, 16'd0);
					again = 1'b1;
				end
				lx_state = ST_START;
			end
			ST_LOGICAL: if (c == 8'd0) begin
				raise_error(ERR_TRUNCATED, 4'd0);
				failed = 1'b1;
			end else if ((c != "&" && c != "|") || c != lx_pend) begin
				raise_error(ERR_INVALID, 4'd0);
				failed = 1'b1;
			end else begin
				put_word(KIND_OP, (c == "&") ? OP_AND : OP_OR, lx_begin, here,
					ERR_NONE, 4'd0, 16'd0, 16'd0);
				lx_state = ST_START;
			end
			default: if (c == 8'd0) begin
				raise_error(ERR_TRUNCATED, 4'd0);
				failed = 1'b1;
			end else if (c != "=") begin
				raise_error(ERR_INVALID, 4'd0);
				failed = 1'b1;
			end else begin
				put_word(KIND_OP, (lx_pend == "!") ? OP_NE : OP_EQ, lx_begin, here,
					ERR_NONE, 4'd0, 16'd0, 16'd0);
				lx_state = ST_START;
			end
			endcase
		end
		if (!failed) begin
			if (c == 8'd0) begin
				put_word(KIND_END, OP_NONE, here, here, ERR_NONE, 4'd0, 16'd0, 16'd0);
				restart_lexer();
			end else begin
				if (c == 8'h0A) begin
					if (lx_line < LINE_LIMIT)
						lx_line++;
					lx_col = 16'd1;
				end else if (lx_col < LINE_LIMIT) begin
					lx_col++;
				end
				if (lx_offset < POS_LIMIT)
					lx_offset++;
			end
		end
		if (step_count > 0)
			step_words[step_count - 1].last = 1'b1;
		for (int i = 0; i < step_count; i++)
			expected_tokens.push_back(step_words[i]);
	endfunction

	function void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			faults++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			restart_lexer();
			expected_tokens.delete();
			faults = 0;
			mismatch_count <= 0;
			tokens_owed <= 0;
		end else begin
			if (char_valid && !char_stall)
				lex_byte(char_code);
			if (result_valid && !result_stall) begin
				if (expected_tokens.size() == 0) begin
					faults++;
					$error("result word with nothing expected: kind %0d", result_kind);
				end else begin
					want = expected_tokens.pop_front();
					check_field("result_kind", want.kind, result_kind);
					check_field("op_code", want.op, op_code);
					check_field("start_offset", want.start_offset, start_offset);
					check_field("end_offset", want.end_offset, end_offset);
					check_field("error_code", want.err_code, error_code);
					check_field("component_count", want.comp, component_count);
					check_field("error_line", want.line, error_line);
					check_field("error_column", want.col, error_column);
					check_field("last_of_run", want.last, last_of_run);
				end
			end
			mismatch_count <= faults;
			tokens_owed <= expected_tokens.size();
		end
	end

endmodule

// ----- tb/sv/version_expression_lexer_tb.sv -----
`timescale 1ns / 1ps

module version_expression_lexer_tb;

	localparam int RANDOM_WORDS   = 1150;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 16;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [7:0]  char_code = 8'h00;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  result_kind;
	logic [2:0]  op_code;
	logic [15:0] start_offset;
	logic [15:0] end_offset;
	logic [1:0]  error_code;
	logic [3:0]  component_count;
	logic [15:0] error_line;
	logic [15:0] error_column;
	logic        last_of_run;

	int mismatch_count;
	int tokens_owed;

	bit send_idle = 1'b1;
	bit stall_idle = 1'b1;
	bit hold_tog = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int words_sent = 0;

	logic [7:0] expr[$];
	string op_texts[10] = '{">=", "<=", ">", "<", "!=", "==", "&&", "||", "(", ")"};
	string lone_ops[4] = '{"&", "|", "!", "="};
	logic [7:0] blanks[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	version_expression_lexer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_valid      (char_valid),
		.char_stall      (char_stall),
		.char_code       (char_code),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result_kind     (result_kind),
		.op_code         (op_code),
		.start_offset    (start_offset),
		.end_offset      (end_offset),
		.error_code      (error_code),
		.component_count (component_count),
		.error_line      (error_line),
		.error_column    (error_column),
		.last_of_run     (last_of_run)
	);

	lexer_token_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_valid      (char_valid),
		.char_stall      (char_stall),
		.char_code       (char_code),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result_kind     (result_kind),
		.op_code         (op_code),
		.start_offset    (start_offset),
		.end_offset      (end_offset),
		.error_code      (error_code),
		.component_count (component_count),
		.error_line      (error_line),
		.error_column    (error_column),
		.last_of_run     (last_of_run),
		.mismatch_count  (mismatch_count),
		.tokens_owed     (tokens_owed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= stall_idle && ($urandom_range(99) < 16);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((char_valid && !char_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("version_expression_lexer_tb: done, errors");
		$finish;
	end

	task automatic send_byte(input logic [7:0] c);
		while (send_idle && $urandom_range(99) < 16) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (char_stall);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic wait_drained();
		char_valid <= 1'b0;
		do @(posedge clk); while (tokens_owed != 0);
	endtask

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(1) != 0) ? 8'("a" + $urandom_range(25)) :
			8'("A" + $urandom_range(25));
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			expr.push_back(s[i]);
	endfunction

	function automatic void make_expression();
		int count;
		int roll;
		int parts;
		expr.delete();
		count = $urandom_range(1, 8);
		for (int t = 0; t < count; t++) begin
			if (t != 0 && $urandom_range(99) < 60)
				expr.push_back(($urandom_range(99) < 70) ? 8'h20 : blanks[$urandom_range(5)]);
			roll = $urandom_range(99);
			if (roll < 30) begin
				expr.push_back(($urandom_range(7) == 0) ? 8'("_") : rand_letter());
				repeat ($urandom_range(5)) begin
					roll = $urandom_range(9);
					expr.push_back((roll < 6) ? rand_letter() :
						(roll < 9) ? 8'("0" + $urandom_range(9)) : 8'("_"));
				end
			end else if (roll < 50) begin
				parts = ($urandom_range(99) < 85) ? 3 : $urandom_range(1, 18);
				for (int p = 0; p < parts; p++) begin
					if (p != 0)
						expr.push_back(".");
					repeat ($urandom_range(1, 3))
						expr.push_back(8'("0" + $urandom_range(9)));
				end
				if ($urandom_range(99) < 5)
					expr.push_back(".");
			end else if (roll < 95) begin
				push_text(op_texts[$urandom_range(9)]);
			end else begin
				expr.push_back(8'($urandom_range(255)));
			end
		end
		roll = $urandom_range(99);
		if (roll < 80) begin
			expr.push_back(8'h00);
		end else if (roll < 88) begin
			push_text(lone_ops[$urandom_range(3)]);
			expr.push_back(8'h00);
		end else if (roll < 94) begin
			expr.push_back(8'($urandom_range(1, 255)));
			expr.push_back(8'h00);
		end
	endfunction

	initial begin
		bit quiet_done;
		bit quiet_over;
		bit held;
		bit paused;
		arst_n <= 1'b0;
		quiet_done = 1'b0;
		quiet_over = 1'b0;
		held = 1'b0;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_byte(8'h00);
		send_text("a>=1.2.3||(_Z9!=b)<=c==d&&e<f>g");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("\n 1.2.3a");
		send_text("1.2 ");
		send_text("9.x");
		send_text("&|");
		send_text("!");
		send_byte(8'h00);
		send_byte(8'h80);

		while (words_sent < RANDOM_WORDS) begin
			if (!quiet_done && words_sent >= 350) begin
				send_idle = 1'b0;
				stall_idle <= 1'b0;
				quiet_done = 1'b1;
			end
			if (!quiet_over && words_sent >= 600) begin
				send_idle = 1'b1;
				stall_idle <= 1'b1;
				quiet_over = 1'b1;
			end
			if (!held && words_sent >= 750) begin
				hold_tog <= ~hold_tog;
				held = 1'b1;
			end
			if (!paused && words_sent >= 950) begin
				wait_drained();
				paused = 1'b1;
			end
			make_expression();
			foreach (expr[i]) begin
				send_byte(expr[i]);
				words_sent++;
			end
		end
		send_byte(8'h00);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && tokens_owed == 0)
			$display("version_expression_lexer_tb: done, clean");
		else
			$display("version_expression_lexer_tb: done, errors");
		$finish;
	end

endmodule

// ----- version_expression_lexer.f -----
hdl/vel_pkg.sv
hdl/vel_step.sv
hdl/vel_out_buf.sv
hdl/version_expression_lexer.sv
tb/sv/lexer_token_checker.sv
tb/sv/version_expression_lexer_tb.sv
